@@ hdl/icsum_pkg.sv @@
// Package for the internet checksum unit: widths, register indexes and the
// structs shared by the accumulator and the top level. No dependencies.
`default_nettype none

package icsum_pkg;

    localparam int unsigned DataW  = 8;
    localparam int unsigned WordW  = 16;
    localparam int unsigned SumW   = 32;
    localparam int unsigned CountW = 17;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 32;
    // Four address halves, the protocol number and the length, all below 2^16.
    localparam int unsigned PseudoW = 19;

    localparam logic [CountW-1:0]  COUNT_SAT    = 17'h1_0000;
    localparam logic [PseudoW-1:0] UDP_PROTOCOL = 19'd17;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CHECKSUM_MODE  = 2'd0,
        CFG_SOURCE_ADDRESS = 2'd1,
        CFG_DEST_ADDRESS   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        MODE_PLAIN = 1'b0,
        MODE_UDP   = 1'b1
    } t_mode;

    // End-of-packet summary handed from the accumulator to the finishing stages.
    typedef struct packed {
        logic [SumW-1:0]  sum;
        logic [WordW-1:0] count;
        logic             overlength;
    } t_pkt_end;

endpackage

`default_nettype wire

@@ hdl/icsum_in_if.sv @@
// Byte channel into the checksum unit: valid/ready with one packet byte and a
// last-byte mark. Depends on icsum_pkg for the widths.
`default_nettype none

interface icsum_in_if;
    logic                          valid;
    logic                          ready;
    logic [icsum_pkg::DataW-1:0]   data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/icsum_out_if.sv @@
// Result channel of the checksum unit: valid/ready with the checksum, the byte
// count and the overlength flag. Depends on icsum_pkg for the widths.
`default_nettype none

interface icsum_out_if;
    logic                          valid;
    logic                          ready;
    logic [icsum_pkg::WordW-1:0]   checksum;
    logic [icsum_pkg::WordW-1:0]   byte_count;
    logic                          overlength;

    modport source (output valid, output checksum, output byte_count, output overlength,
                    input ready);
    modport sink   (input valid, input checksum, input byte_count, input overlength,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/icsum_acc.sv @@
// Per-byte accumulator: pairs bytes into big-endian words, adds them and counts
// bytes; on the last byte it registers the packet summary. Uses icsum_pkg.
`default_nettype none

module icsum_acc (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_xfer,
    input  wire logic [icsum_pkg::DataW-1:0]   i_data_byte,
    input  wire logic                          i_last_byte,
    output logic                               o_end_valid,
    output icsum_pkg::t_pkt_end                o_end
);

    logic [icsum_pkg::SumW-1:0]   r_sum;
    logic [icsum_pkg::DataW-1:0]  r_hold;
    logic                         r_odd;
    logic [icsum_pkg::CountW-1:0] r_count;
    logic                         r_end_valid;
    icsum_pkg::t_pkt_end          r_end;

    logic [icsum_pkg::CountW-1:0] n_count;
    logic [icsum_pkg::WordW-1:0]  n_word;
    logic [icsum_pkg::SumW-1:0]   n_sum;

    always_comb begin
        n_count = (r_count == icsum_pkg::COUNT_SAT) ? r_count
                                                    : r_count + icsum_pkg::CountW'(1);
        // A byte in the high position that ends the packet is padded low with zero.
        n_word  = r_odd ? {r_hold, i_data_byte} : {i_data_byte, 8'h00};
        n_sum   = r_sum + {16'h0000, n_word};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_odd       <= 1'b0;
            r_count     <= '0;
            r_end_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_end_valid <= i_xfer && i_last_byte;
            end
            if (i_xfer) begin
                if (i_last_byte) begin
                    r_sum   <= '0;
                    r_odd   <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_count <= n_count;
                    if (r_odd) begin
                        r_sum <= n_sum;
                        r_odd <= 1'b0;
                    end else begin
                        r_odd <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_xfer && !r_odd) begin
            r_hold <= i_data_byte;
        end
        if (i_xfer && i_last_byte) begin
            r_end.sum        <= n_sum;
            r_end.count      <= n_count[icsum_pkg::CountW-1] ? 16'hFFFF
                                                             : n_count[icsum_pkg::WordW-1:0];
            r_end.overlength <= n_count[icsum_pkg::CountW-1];
        end
    end

    assign o_end_valid = r_end_valid;
    assign o_end       = r_end;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_xfer && i_last_byte) |=> (r_sum == '0 && !r_odd && r_count == '0))
        else $error("accumulator not cleared after the last byte");

    a_odd_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_xfer && !i_last_byte) |=> (r_odd != $past(r_odd)))
        else $error("byte position did not alternate");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= icsum_pkg::COUNT_SAT)
        else $error("byte counter passed its saturation value");
`endif

endmodule

`default_nettype wire

@@ hdl/internet_checksum_udp_unit.sv @@
// Top level of the internet checksum unit: configuration registers, the
// pseudo-header and fold stages and the result register. Uses icsum_pkg,
// icsum_in_if, icsum_out_if and icsum_acc.
//
// Usage: a packet enters one byte per transfer on i_in, in network order,
// with last_byte set on its final byte. One result per packet leaves on o_out:
// the complemented folded one's complement sum, the byte count (saturated at
// 65535) and an overlength flag for packets over 65535 bytes.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_index
// (0 mode, 1 source address, 2 destination address); other indexes are ignored.
// Mode 1 adds the UDP pseudo header (both addresses, protocol 17, length).
// Throughput is one byte per cycle while o_out is not stalled; packets follow each other with no gap.
// Pipeline: the accumulator's summary register is loaded at the last byte's
// transfer, then the pseudo-header add, final add and fold/output registers
// follow in turn; the result is valid on o_out from the output register.
// Stalls: all stages advance together; while a result waits on o_out.ready
// the pipeline holds and i_in.ready is low, otherwise i_in.ready is high.
// Reset (synchronous, active low) clears the registers, the packet state
// and all stage valids.
`default_nettype none

module internet_checksum_udp_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [icsum_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [icsum_pkg::CfgDataW-1:0]    i_cfg_data,
    icsum_in_if.sink                               i_in,
    icsum_out_if.source                            o_out
);

    icsum_pkg::t_mode              r_mode;
    logic [31:0]                   r_src_addr;
    logic [31:0]                   r_dst_addr;

    logic                          en;
    logic                          xfer;
    logic                          end_valid;
    icsum_pkg::t_pkt_end           end_info;

    logic                          r_b_valid;
    icsum_pkg::t_pkt_end           r_b_end;
    logic [icsum_pkg::PseudoW-1:0] r_b_pseudo;
    logic                          r_c_valid;
    icsum_pkg::t_pkt_end           r_c_end;
    logic                          r_out_valid;
    logic [icsum_pkg::WordW-1:0]   r_out_checksum;
    logic [icsum_pkg::WordW-1:0]   r_out_count;
    logic                          r_out_ovl;

    logic [icsum_pkg::PseudoW-1:0] n_b_pseudo;
    logic [icsum_pkg::WordW:0]     fold1;
    logic [icsum_pkg::WordW-1:0]   fold2;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;
    assign xfer       = i_in.valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= icsum_pkg::MODE_PLAIN;
            r_src_addr <= '0;
            r_dst_addr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icsum_pkg::CFG_CHECKSUM_MODE:  r_mode     <= icsum_pkg::t_mode'(i_cfg_data[0]);
                icsum_pkg::CFG_SOURCE_ADDRESS: r_src_addr <= i_cfg_data;
                icsum_pkg::CFG_DEST_ADDRESS:   r_dst_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    icsum_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_xfer      (xfer),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_end_valid (end_valid),
        .o_end       (end_info)
    );

    always_comb begin
        n_b_pseudo = '0;
        if (r_mode == icsum_pkg::MODE_UDP) begin
            n_b_pseudo = icsum_pkg::PseudoW'(r_src_addr[31:16])
                       + icsum_pkg::PseudoW'(r_src_addr[15:0])
                       + icsum_pkg::PseudoW'(r_dst_addr[31:16])
                       + icsum_pkg::PseudoW'(r_dst_addr[15:0])
                       + icsum_pkg::UDP_PROTOCOL
                       + icsum_pkg::PseudoW'(end_info.count);
        end
        // Two folds always fit: a carry out of the first leaves a low half below 0xffff.
        fold1 = {1'b0, r_c_end.sum[31:16]} + {1'b0, r_c_end.sum[15:0]};
        fold2 = fold1[icsum_pkg::WordW] ? fold1[icsum_pkg::WordW-1:0] + 16'd1
                                        : fold1[icsum_pkg::WordW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b_valid   <= end_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_end        <= end_info;
            r_b_pseudo     <= n_b_pseudo;
            r_c_end.sum    <= r_b_end.sum + {13'h0000, r_b_pseudo};
            r_c_end.count      <= r_b_end.count;
            r_c_end.overlength <= r_b_end.overlength;
            r_out_checksum <= ~fold2;
            r_out_count    <= r_c_end.count;
            r_out_ovl      <= r_c_end.overlength;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.checksum   = r_out_checksum;
    assign o_out.byte_count = r_out_count;
    assign o_out.overlength = r_out_ovl;

`ifndef SYNTHESIS
    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && en) |=> r_out_valid)
        else $error("finished sum did not reach the result register");

    a_overlength_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovl) |-> (r_out_count == 16'hFFFF))
        else $error("overlength result without a saturated byte count");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("result with a byte count of zero");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while the pipeline is stalled");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for internet_checksum_udp_unit: byte packets in, one checksum per
// packet out, compared against a behavioural predictor held in a small scoreboard class.
// Depends on icsum_pkg, icsum_in_if, icsum_out_if and the unit itself.

class checksum_scoreboard;
    typedef struct {
        logic [15:0] checksum;
        logic [15:0] byte_count;
        logic        overlength;
    } t_packet_sum;

    icsum_pkg::t_mode mode;
    bit [31:0]        src_addr;
    bit [31:0]        dst_addr;

    bit [31:0]        running_sum;
    bit [7:0]         held_high;
    bit               odd_byte;
    bit [16:0]        packet_bytes;

    t_packet_sum      awaiting_sums[$];
    int               failures;
    int               results_checked;

    function new();
        mode = icsum_pkg::MODE_PLAIN;
        src_addr = '0;
        dst_addr = '0;
        clear_packet();
        failures = 0;
        results_checked = 0;
    endfunction

    function void clear_packet();
        running_sum = '0;
        held_high = '0;
        odd_byte = 1'b0;
        packet_bytes = '0;
    endfunction

    function void set_register(icsum_pkg::t_cfg_idx idx, bit [31:0] value);
        case (idx)
            icsum_pkg::CFG_CHECKSUM_MODE:  mode = icsum_pkg::t_mode'(value[0]);
            icsum_pkg::CFG_SOURCE_ADDRESS: src_addr = value;
            icsum_pkg::CFG_DEST_ADDRESS:   dst_addr = value;
            default: ;
        endcase
    endfunction

    function bit [15:0] fold_twice(bit [31:0] total);
        bit [31:0] folded;
        folded = {16'd0, total[31:16]} + {16'd0, total[15:0]};
        folded = {16'd0, folded[31:16]} + {16'd0, folded[15:0]};
        return folded[15:0];
    endfunction

    // Called for every byte transfer on the input channel.
    function void note_byte(bit [7:0] data, bit last);
        bit [31:0]   total;
        bit [15:0]   count16;
        t_packet_sum e;
        if (packet_bytes < icsum_pkg::COUNT_SAT)
            packet_bytes++;
        if (!odd_byte) begin
            held_high = data;
            odd_byte = 1'b1;
        end else begin
            running_sum += {16'd0, held_high, data};
            odd_byte = 1'b0;
        end
        if (!last)
            return;
        total = running_sum;
        if (odd_byte)
            total += {16'd0, held_high, 8'd0};
        count16 = packet_bytes[16] ? 16'hffff : packet_bytes[15:0];
        if (mode == icsum_pkg::MODE_UDP) begin
            total += {16'd0, src_addr[31:16]};
            total += {16'd0, src_addr[15:0]};
            total += {16'd0, dst_addr[31:16]};
            total += {16'd0, dst_addr[15:0]};
            total += 32'(icsum_pkg::UDP_PROTOCOL) + {16'd0, count16};
        end
        e.checksum = ~fold_twice(total);
        e.byte_count = count16;
        e.overlength = packet_bytes[16];
        awaiting_sums.push_back(e);
        clear_packet();
    endfunction

    // Called for every result transfer on the output channel.
    function void check_result(logic [15:0] checksum, logic [15:0] byte_count,
                               logic overlength);
        t_packet_sum e;
        results_checked++;
        if (awaiting_sums.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("Unexpected result: checksum %h count %0d overlength %b",
                         checksum, byte_count, overlength);
            return;
        end
        e = awaiting_sums.pop_front();
        if (checksum !== e.checksum || byte_count !== e.byte_count
                || overlength !== e.overlength) begin
            failures++;
            if (failures <= 10)
                $display("Mismatch on result %0d: expected %h/%0d/%b, got %h/%0d/%b",
                         results_checked, e.checksum, e.byte_count, e.overlength,
                         checksum, byte_count, overlength);
        end
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_BYTES   = 1050;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [icsum_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic [icsum_pkg::CfgDataW-1:0] i_cfg_data;

    icsum_in_if  byte_bus ();
    icsum_out_if sum_bus ();

    checksum_scoreboard sb = new();

    bit no_idle;
    bit hold_request;
    bit hold_done;
    int bytes_sent;
    int settings_used;
    int longest_packet;

    internet_checksum_udp_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (byte_bus),
        .o_out       (sum_bus)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_byte(input bit [7:0] data, input bit last);
        if (!no_idle && $urandom_range(0, 99) < 7) begin
            byte_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= data;
        byte_bus.last_byte <= last;
        do @(posedge i_clk); while (!byte_bus.ready);
        sb.note_byte(data, last);
        bytes_sent++;
    endtask

    function automatic bit [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hff;
        return 8'($urandom);
    endfunction

    task automatic send_packet(input int unsigned len, input bit fixed, input bit [7:0] fill);
        for (int unsigned k = 1; k <= len; k++)
            send_byte(fixed ? fill : pick_byte(), k == len);
        if (len > longest_packet)
            longest_packet = len;
    endtask

    // The write enable is raised once for all three writes and lowered after the last.
    task automatic configure(input icsum_pkg::t_mode mode, input logic [31:0] src,
                             input logic [31:0] dst);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= icsum_pkg::CFG_CHECKSUM_MODE;
        i_cfg_data  <= {31'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= icsum_pkg::CFG_SOURCE_ADDRESS;
        i_cfg_data  <= src;
        @(posedge i_clk);
        i_cfg_index <= icsum_pkg::CFG_DEST_ADDRESS;
        i_cfg_data  <= dst;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_register(icsum_pkg::CFG_CHECKSUM_MODE, {31'd0, mode});
        sb.set_register(icsum_pkg::CFG_SOURCE_ADDRESS, src);
        sb.set_register(icsum_pkg::CFG_DEST_ADDRESS, dst);
        settings_used++;
    endtask

    // Waits until every packet sent so far has produced its result, then lets the
    // pipeline settle before anything is reconfigured.
    task automatic drain();
        byte_bus.valid <= 1'b0;
        while (sb.awaiting_sums.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_address();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 4)
            return '1;
        return $urandom;
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 8);
        if (r < 90)
            return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (sum_bus.valid && sum_bus.ready)
                sb.check_result(sum_bus.checksum, sum_bus.byte_count, sum_bus.overlength);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                sum_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            sum_bus.ready <= no_idle || ($urandom_range(0, 99) >= 7);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (byte_bus.valid && byte_bus.ready)
                    || (sum_bus.valid && sum_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int phase_bytes;
        int phase_packets;
        int random_start;
        int unsigned len;
        int leftover;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= icsum_pkg::CFG_CHECKSUM_MODE;
        i_cfg_data         <= '0;
        byte_bus.valid     <= 1'b0;
        byte_bus.data_byte <= '0;
        byte_bus.last_byte <= 1'b0;
        sum_bus.ready      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: plain checksum. Single bytes, odd and even lengths.
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hfe, 1'b1);
        drain();

        // Pseudo header with both addresses at their extremes.
        configure(icsum_pkg::MODE_UDP, '1, '1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();
        configure(icsum_pkg::MODE_UDP, '0, '0);
        send_byte(8'hab, 1'b1);
        send_byte(8'hcd, 1'b0);
        send_byte(8'hef, 1'b1);
        drain();
        // Addresses set but plain mode: they must not count.
        configure(icsum_pkg::MODE_PLAIN, 32'hc0a8_0001, 32'h0a00_00ff);
        send_byte(8'h5a, 1'b0);
        send_byte(8'ha5, 1'b1);
        drain();

        // Random phases, each under its own register setting.
        random_start = bytes_sent;
        phase = 0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            phase++;
            configure(icsum_pkg::t_mode'($urandom_range(0, 1)), pick_address(),
                      pick_address());
            no_idle = (phase == 3);
            phase_bytes = 0;
            phase_packets = 0;
            while (phase_bytes < 150) begin
                if (phase == 2 && phase_packets == 2)
                    hold_request = 1'b1;
                len = pick_length();
                send_packet(len, 1'b0, 8'h00);
                phase_bytes += len;
                phase_packets++;
            end
            drain();
        end
        no_idle = 1'b0;
        repeat (8) @(posedge i_clk);

        leftover = sb.awaiting_sums.size();
        $display("Run covered %0d bytes and %0d packet results under %0d register settings,",
                 bytes_sent, sb.results_checked, settings_used);
        $display("with packets up to %0d bytes, a long result hold-off and both modes.",
                 longest_packet);
        if (sb.failures == 0 && leftover == 0) begin
            $display("== PASS ==");
        end else begin
            $display("Failures: %0d mismatches, %0d results never arrived",
                     sb.failures, leftover);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
